>>> hw/rtl/float32_multiply_truncated_assert.svh
// Assertion macros used by float32_multiply_truncated.
`ifndef FLOAT32_MULTIPLY_TRUNCATED_ASSERT_SVH
`define FLOAT32_MULTIPLY_TRUNCATED_ASSERT_SVH

// label: implication checked every clock, skipped during reset
`define FMT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// label: implication whose consequent is checked in the next cycle
`define FMT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fmt_pkg.sv
package fmt_pkg;
    localparam int unsigned MantW = 23;
    localparam int unsigned ExpW  = 8;
    localparam logic [ExpW-1:0] ExpInf = 8'd255;
    localparam logic [9:0] BiasHi = 10'd126;
    localparam logic [9:0] BiasLo = 10'd127;
    localparam logic [9:0] ExpMax = 10'd254;

    // stage 1 -> stage 2 intermediate
    typedef struct packed {
        logic        sign;
        logic        zero_in;
        logic [8:0]  esum;
        logic [25:0] hh;
        logic [12:0] hl_top;
        logic [12:0] lh_top;
    } fmt_part_t;
endpackage

>>> hw/rtl/fmt_partial.sv
module fmt_partial (
    input  logic [31:0]       operand_a,
    input  logic [31:0]       operand_b,
    output fmt_pkg::fmt_part_t part
);
    import fmt_pkg::*;

    logic [23:0] ma, mb;
    logic [23:0] hl, lh;

    always_comb begin
        ma = {1'b1, operand_a[22:0]};
        mb = {1'b1, operand_b[22:0]};
        hl = 24'(ma[23:11]) * 24'(mb[10:0]);
        lh = 24'(ma[10:0]) * 24'(mb[23:11]);
        part.sign    = operand_a[31] ^ operand_b[31];
        part.zero_in = (operand_a[30:23] == '0) || (operand_b[30:23] == '0);
        part.esum    = {1'b0, operand_a[30:23]} + {1'b0, operand_b[30:23]};
        part.hh      = 26'(ma[23:11]) * 26'(mb[23:11]);
        part.hl_top  = hl[23:11];
        part.lh_top  = lh[23:11];
    end
endmodule

>>> hw/rtl/float32_multiply_truncated.sv
// Pipeline: partial-product stage into part_reg, then sum/normalize stage into
//   the output register.
// Throughput: one beat per cycle unless m_tready stalls; three 13x13/13x11 multipliers feed stage 1.
// Reset: aresetn synchronous active low clears the valid flags; no other state.
module float32_multiply_truncated (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // product [31:0]
);
    import fmt_pkg::*;

    fmt_part_t   part_next, part_reg;
    logic        v1_reg, v2_reg;
    logic [31:0] prod_reg, prod_next;
    logic        adv2, adv1;
    logic [25:0] sum;
    logic [9:0]  ex;
    logic [22:0] mant;

    fmt_partial u_part (
        .operand_a(s_tdata[31:0]),
        .operand_b(s_tdata[63:32]),
        .part     (part_next)
    );

    assign adv2     = !v2_reg || m_tready;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v2_reg;
    assign m_tdata  = prod_reg;

    always_comb begin
        sum = part_reg.hh + 26'(part_reg.hl_top) + 26'(part_reg.lh_top) + 26'd2;
        if (sum[25]) begin
            mant = sum[24:2];
            ex   = {1'b0, part_reg.esum} - BiasHi;
        end else begin
            mant = sum[23:1];
            ex   = {1'b0, part_reg.esum} - BiasLo;
        end
        if (part_reg.zero_in || ex[9] || ex == '0) begin
            prod_next = {part_reg.sign, 31'd0};
        end else if (ex > ExpMax) begin
            prod_next = {part_reg.sign, ExpInf, 23'd0};
        end else begin
            prod_next = {part_reg.sign, ex[7:0], mant};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1 && s_tvalid) part_reg <= part_next;
        if (adv2 && v1_reg) prod_reg <= prod_next;
    end

`include "float32_multiply_truncated_assert.svh"
    `FMT_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    `FMT_ASSERT_NXT(a_flow, aclk, aresetn, v1_reg && adv2, m_tvalid, "stage 1 beat lost")
    `FMT_ASSERT_IMP(a_zero, aclk, aresetn, m_tvalid && m_tdata[30:23] == '0, m_tdata[22:0] == '0, "zero result with mantissa")
endmodule
